FILE: src/hole_allocator_with_swap_out_top_defines.svh
// Assertion macros for the hole allocator checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef HOLE_ALLOCATOR_WITH_SWAP_OUT_TOP_DEFINES_SVH
`define HOLE_ALLOCATOR_WITH_SWAP_OUT_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define HASW_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error("hasw assertion failed");

// Next-cycle implication, disabled during reset
`define HASW_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) \
    else $error("hasw assertion failed");

`endif

FILE: src/hasw_pkg.sv
// Shared types, constants and command codes of the hole allocator.
// No dependencies.
package hasw_pkg;

  localparam int MemUnits = 128;
  localparam int MaxSeg   = 32;
  localparam int IdxW     = 5;
  localparam int CntW     = 6;
  localparam int SizeW    = 8;
  localparam int TimeW    = 32;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 4;
  localparam int OpW      = 4;

  // segment kinds
  localparam logic KindHole = 1'b0;
  localparam logic KindProc = 1'b1;

  // fit modes
  localparam logic [1:0] FitFirst = 2'd0;
  localparam logic [1:0] FitNext  = 2'd1;
  localparam logic [1:0] FitBest  = 2'd2;
  localparam logic [1:0] FitWorst = 2'd3;

  // record kinds
  localparam logic [1:0] RecRequeue = 2'd0;
  localparam logic [1:0] RecDrop    = 2'd1;
  localparam logic [1:0] RecLoad    = 2'd2;
  localparam logic [1:0] RecReject  = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgFitMode   = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgSwapLimit = 1'd1;

  // datapath commands
  localparam logic [OpW-1:0] OpNone      = 4'd0;
  localparam logic [OpW-1:0] OpAccept    = 4'd1;
  localparam logic [OpW-1:0] OpFindInit  = 4'd2;
  localparam logic [OpW-1:0] OpFindStep  = 4'd3;
  localparam logic [OpW-1:0] OpOldInit   = 4'd4;
  localparam logic [OpW-1:0] OpOldStep   = 4'd5;
  localparam logic [OpW-1:0] OpEvict     = 4'd6;
  localparam logic [OpW-1:0] OpMergeInit = 4'd7;
  localparam logic [OpW-1:0] OpMergeStep = 4'd8;
  localparam logic [OpW-1:0] OpMergeFin  = 4'd9;
  localparam logic [OpW-1:0] OpPosInit   = 4'd10;
  localparam logic [OpW-1:0] OpPosStep   = 4'd11;
  localparam logic [OpW-1:0] OpPlace     = 4'd12;
  localparam logic [OpW-1:0] OpEmitEv    = 4'd13;
  localparam logic [OpW-1:0] OpEmitLd    = 4'd14;
  localparam logic [OpW-1:0] OpEmitRj    = 4'd15;

  typedef struct packed {
    logic [7:0] process_id;
    logic [7:0] process_size;
    logic [3:0] swap_count;
  } req_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [7:0]  record_id;
    logic [7:0]  record_size;
    logic [3:0]  record_swaps;
    logic [6:0]  load_position;
    logic [7:0]  resident_count;
    logic [7:0]  hole_count;
    logic [7:0]  units_used;
    logic [31:0] loads_done;
    logic        last_record;
  } rec_t;

  typedef struct packed {
    logic [OpW-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic bad_size;
    logic find_stop;
    logic fits;
    logic old_stop;
    logic any_proc;
    logic merge_done;
    logic pos_done;
  } stat_t;

endpackage

FILE: src/hasw_dp.sv
// Datapath: segment table, scan counter, usage counters and record register.
// Depends on hasw_pkg; driven by hasw_ctrl commands.
module hasw_dp import hasw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  req_t                req_i,
  input  cmd_t                cmd_i,
  output stat_t               stat_o,
  output logic                result_valid_o,
  output rec_t                result_o
);

  // segment table
  logic             kind_q  [MaxSeg];
  logic [SizeW-1:0] size_q  [MaxSeg];
  logic [7:0]       owner_q [MaxSeg];
  logic [TimeW-1:0] time_q  [MaxSeg];
  logic [3:0]       swaps_q [MaxSeg];

  logic [CntW-1:0]  n_q, n_d;
  logic [IdxW-1:0]  start_q, start_d;
  logic [TimeW-1:0] lc_q;
  logic [1:0]       fit_q;
  logic [3:0]       lim_q;
  req_t             req_q;
  logic [CntW-1:0]  k_q;
  logic             found_q;
  logic [IdxW-1:0]  pick_q;
  logic [SizeW-1:0] pick_sz_q;
  logic             any_q;
  logic [IdxW-1:0]  old_q;
  logic [TimeW-1:0] old_t_q;
  logic             prev_q;
  logic [SizeW-1:0] pos_q;
  logic [CntW-1:0]  res_q;
  logic [SizeW-1:0] units_q;
  logic [7:0]       ev_id_q;
  logic [SizeW-1:0] ev_sz_q;
  logic [3:0]       ev_sw_q;
  logic             valid_q;
  rec_t             rec_q;

  logic [CntW:0]    nf_sum, nf_wrap;
  logic [IdxW-1:0]  idx;
  logic             rd_kind;
  logic [SizeW-1:0] rd_size;
  logic [TimeW-1:0] rd_time;
  logic [3:0]       rd_sw;
  logic             hit, take, merge_hit, do_ins, do_rem;
  logic [CntW-1:0]  pick_nx;

  // choose the table entry under scan: circular for next fit, the oldest process for eviction
  assign nf_sum  = (CntW+1)'(start_q) + (CntW+1)'(k_q);
  assign nf_wrap = (nf_sum >= (CntW+1)'(n_q)) ? nf_sum - (CntW+1)'(n_q) : nf_sum;

  always_comb begin
    if (cmd_i.op == OpEvict) begin
      idx = old_q;
    end else if (cmd_i.op == OpFindStep && fit_q == FitNext) begin
      idx = nf_wrap[IdxW-1:0];
    end else begin
      idx = k_q[IdxW-1:0];
    end
  end

  assign rd_kind = kind_q[idx];
  assign rd_size = size_q[idx];
  assign rd_time = time_q[idx];
  assign rd_sw   = swaps_q[idx];

  assign hit  = (rd_kind == KindHole) && (rd_size >= req_q.process_size);
  assign take = hit && (!fit_q[1] || !found_q ||
                        (fit_q == FitBest  && rd_size < pick_sz_q) ||
                        (fit_q == FitWorst && rd_size > pick_sz_q));
  assign merge_hit = (rd_kind == KindHole) && prev_q;
  assign do_rem  = (cmd_i.op == OpMergeStep) && merge_hit;
  assign do_ins  = (cmd_i.op == OpPlace) && (pick_sz_q != req_q.process_size);
  assign pick_nx = CntW'(pick_q) + CntW'(1);

  // status to the controller
  assign stat_o.bad_size   = (req_i.process_size == '0) ||
                             (req_i.process_size > SizeW'(MemUnits));
  assign stat_o.find_stop  = (k_q == n_q - CntW'(1)) || (hit && !fit_q[1]);
  assign stat_o.fits       = found_q && ((pick_sz_q == req_q.process_size) ||
                                         (n_q < CntW'(MaxSeg)));
  assign stat_o.old_stop   = (k_q == n_q - CntW'(1));
  assign stat_o.any_proc   = any_q;
  assign stat_o.merge_done = (k_q >= n_q);
  assign stat_o.pos_done   = (k_q == CntW'(pick_q));

  // table kind and size, with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MaxSeg; j++) begin
        kind_q[j] <= KindHole;
        size_q[j] <= '0;
      end
      size_q[0] <= SizeW'(MemUnits);
    end else begin
      if (do_rem) begin
        for (int j = 0; j < MaxSeg - 1; j++) begin
          if (IdxW'(j) >= k_q[IdxW-1:0]) begin
            kind_q[j] <= kind_q[j+1];
            size_q[j] <= size_q[j+1];
          end
        end
        size_q[k_q[IdxW-1:0] - IdxW'(1)] <= size_q[k_q[IdxW-1:0] - IdxW'(1)] + rd_size;
      end
      if (cmd_i.op == OpEvict) begin
        kind_q[old_q] <= KindHole;
      end
      if (cmd_i.op == OpPlace) begin
        if (do_ins) begin
          for (int j = 1; j < MaxSeg; j++) begin
            if (IdxW'(j) > pick_q) begin
              kind_q[j] <= kind_q[j-1];
              size_q[j] <= size_q[j-1];
            end
          end
          size_q[pick_nx[IdxW-1:0]] <= pick_sz_q - req_q.process_size;
        end
        kind_q[pick_q] <= KindProc;
        size_q[pick_q] <= req_q.process_size;
      end
    end
  end

  // table owner, load time and swaps: written before read
  always_ff @(posedge clk_i) begin
    if (do_rem) begin
      for (int j = 0; j < MaxSeg - 1; j++) begin
        if (IdxW'(j) >= k_q[IdxW-1:0]) begin
          owner_q[j] <= owner_q[j+1];
          time_q[j]  <= time_q[j+1];
          swaps_q[j] <= swaps_q[j+1];
        end
      end
    end
    if (cmd_i.op == OpPlace) begin
      if (do_ins) begin
        for (int j = 1; j < MaxSeg; j++) begin
          if (IdxW'(j) > pick_q) begin
            owner_q[j] <= owner_q[j-1];
            time_q[j]  <= time_q[j-1];
            swaps_q[j] <= swaps_q[j-1];
          end
        end
      end
      owner_q[pick_q] <= req_q.process_id;
      time_q[pick_q]  <= lc_q;
      swaps_q[pick_q] <= req_q.swap_count;
    end
  end

  // segment count and next-fit start
  always_comb begin
    n_d     = n_q;
    start_d = start_q;
    unique case (cmd_i.op)
      OpMergeStep: begin
        if (merge_hit) begin
          n_d = n_q - CntW'(1);
          if (CntW'(start_q) == k_q) begin
            start_d = start_q - IdxW'(1);
          end else if (CntW'(start_q) > k_q) begin
            start_d = start_q - IdxW'(1);
          end
        end
      end
      OpMergeFin: begin
        if (CntW'(start_q) >= n_q) begin
          start_d = '0;
        end
      end
      OpPlace: begin
        if (do_ins) begin
          n_d = n_q + CntW'(1);
        end
        start_d = pick_nx[IdxW-1:0];
        if (pick_nx >= n_d) begin
          start_d = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // control and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q     <= CntW'(1);
      start_q <= '0;
      lc_q    <= '0;
      fit_q   <= FitFirst;
      lim_q   <= 4'd3;
      res_q   <= '0;
      units_q <= '0;
      valid_q <= 1'b0;
    end else begin
      n_q     <= n_d;
      start_q <= start_d;
      valid_q <= (cmd_i.op == OpEmitEv) || (cmd_i.op == OpEmitLd) ||
                 (cmd_i.op == OpEmitRj);
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgFitMode:   fit_q <= cfg_data_i[1:0];
          CfgSwapLimit: lim_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.op == OpEvict) begin
        res_q   <= res_q - CntW'(1);
        units_q <= units_q - rd_size;
      end
      if (cmd_i.op == OpPlace) begin
        res_q   <= res_q + CntW'(1);
        units_q <= units_q + req_q.process_size;
        lc_q    <= lc_q + TimeW'(1);
      end
    end
  end

  // scan registers, request and record
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OpAccept: req_q <= req_i;
      OpFindInit: begin
        k_q     <= '0;
        found_q <= 1'b0;
      end
      OpFindStep: begin
        if (take) begin
          found_q   <= 1'b1;
          pick_q    <= idx;
          pick_sz_q <= rd_size;
        end
        k_q <= k_q + CntW'(1);
      end
      OpOldInit: begin
        k_q   <= '0;
        any_q <= 1'b0;
      end
      OpOldStep: begin
        if (rd_kind == KindProc && (!any_q || rd_time < old_t_q)) begin
          any_q   <= 1'b1;
          old_q   <= idx;
          old_t_q <= rd_time;
        end
        k_q <= k_q + CntW'(1);
      end
      OpEvict: begin
        ev_id_q <= owner_q[idx];
        ev_sz_q <= rd_size;
        ev_sw_q <= (rd_sw == 4'd15) ? rd_sw : rd_sw + 4'd1;
      end
      OpMergeInit: begin
        k_q    <= '0;
        prev_q <= 1'b0;
      end
      OpMergeStep: begin
        if (!merge_hit) begin
          prev_q <= (rd_kind == KindHole);
          k_q    <= k_q + CntW'(1);
        end
      end
      OpPosInit: begin
        k_q   <= '0;
        pos_q <= '0;
      end
      OpPosStep: begin
        pos_q <= pos_q + rd_size;
        k_q   <= k_q + CntW'(1);
      end
      OpEmitEv: begin
        rec_q.record_kind   <= (ev_sw_q < lim_q) ? RecRequeue : RecDrop;
        rec_q.record_id     <= ev_id_q;
        rec_q.record_size   <= ev_sz_q;
        rec_q.record_swaps  <= ev_sw_q;
        rec_q.load_position <= '0;
        rec_q.last_record   <= 1'b0;
      end
      OpEmitLd: begin
        rec_q.record_kind   <= RecLoad;
        rec_q.record_id     <= req_q.process_id;
        rec_q.record_size   <= req_q.process_size;
        rec_q.record_swaps  <= req_q.swap_count;
        rec_q.load_position <= pos_q[6:0];
        rec_q.last_record   <= 1'b1;
      end
      OpEmitRj: begin
        rec_q.record_kind   <= RecReject;
        rec_q.record_id     <= req_q.process_id;
        rec_q.record_size   <= req_q.process_size;
        rec_q.record_swaps  <= req_q.swap_count;
        rec_q.load_position <= '0;
        rec_q.last_record   <= 1'b1;
      end
      default: begin
      end
    endcase
    rec_q.resident_count <= 8'(res_q);
    rec_q.hole_count     <= 8'(n_q - res_q);
    rec_q.units_used     <= units_q;
    rec_q.loads_done     <= lc_q;
  end

  assign result_valid_o = valid_q;
  assign result_o       = rec_q;

endmodule

FILE: src/hasw_ctrl.sv
// Controller: sequences table walks, evictions and record emission.
// Depends on hasw_pkg; commands hasw_dp.
module hasw_ctrl import hasw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  output logic  busy,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [3:0] SIdle      = 4'd0;
  localparam logic [3:0] SFindInit  = 4'd1;
  localparam logic [3:0] SFind      = 4'd2;
  localparam logic [3:0] SDecide    = 4'd3;
  localparam logic [3:0] SPosInit   = 4'd4;
  localparam logic [3:0] SPos       = 4'd5;
  localparam logic [3:0] SEmitLd    = 4'd6;
  localparam logic [3:0] SOldInit   = 4'd7;
  localparam logic [3:0] SOld       = 4'd8;
  localparam logic [3:0] SOldDec    = 4'd9;
  localparam logic [3:0] SEvict     = 4'd10;
  localparam logic [3:0] SMergeInit = 4'd11;
  localparam logic [3:0] SMerge     = 4'd12;
  localparam logic [3:0] SEmitEv    = 4'd13;
  localparam logic [3:0] SEmitRj    = 4'd14;

  logic [3:0] state_q, state_d;

  // next state and command
  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OpNone;
    unique case (state_q)
      SIdle: begin
        if (start) begin
          cmd_o.op = OpAccept;
          state_d  = stat_i.bad_size ? SEmitRj : SFindInit;
        end
      end
      SFindInit: begin
        cmd_o.op = OpFindInit;
        state_d  = SFind;
      end
      SFind: begin
        cmd_o.op = OpFindStep;
        if (stat_i.find_stop) state_d = SDecide;
      end
      SDecide:  state_d = stat_i.fits ? SPosInit : SOldInit;
      SPosInit: begin
        cmd_o.op = OpPosInit;
        state_d  = SPos;
      end
      SPos: begin
        if (stat_i.pos_done) begin
          cmd_o.op = OpPlace;
          state_d  = SEmitLd;
        end else begin
          cmd_o.op = OpPosStep;
        end
      end
      SEmitLd: begin
        cmd_o.op = OpEmitLd;
        state_d  = SIdle;
      end
      SOldInit: begin
        cmd_o.op = OpOldInit;
        state_d  = SOld;
      end
      SOld: begin
        cmd_o.op = OpOldStep;
        if (stat_i.old_stop) state_d = SOldDec;
      end
      SOldDec:  state_d = stat_i.any_proc ? SEvict : SEmitRj;
      SEvict: begin
        cmd_o.op = OpEvict;
        state_d  = SMergeInit;
      end
      SMergeInit: begin
        cmd_o.op = OpMergeInit;
        state_d  = SMerge;
      end
      SMerge: begin
        if (stat_i.merge_done) begin
          cmd_o.op = OpMergeFin;
          state_d  = SEmitEv;
        end else begin
          cmd_o.op = OpMergeStep;
        end
      end
      SEmitEv: begin
        cmd_o.op = OpEmitEv;
        state_d  = SFindInit;
      end
      SEmitRj: begin
        cmd_o.op = OpEmitRj;
        state_d  = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  // hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != SIdle);

endmodule

FILE: src/hole_allocator_with_swap_out_top.sv
// Top level of the hole allocator: controller plus datapath.
// Depends on hasw_pkg, hasw_ctrl and hasw_dp.
//
//  channel   handshake            payload
//  request   start & !busy        req_i (req_t)
//  record    result_valid_o       result_o (rec_t), one cycle, no stall
//  config    cfg_we_i             cfg_idx_i, cfg_data_i
//
// A request walks the segment table of n entries one entry a cycle: a fit
// scan of up to n entries, then a position walk; each eviction adds an
// oldest-process walk of n entries, a merge walk and a fresh fit scan of up
// to n entries. Records are registered and leave in the cycle after emission.
// Reset leaves one hole spanning all memory; results cannot be stalled.
module hole_allocator_with_swap_out_top import hasw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  req_t                req_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                result_valid_o,
  output rec_t                result_o
);

  cmd_t  cmd;
  stat_t stat;

  hasw_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  hasw_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .req_i          (req_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

FILE: src/hasw_checker.sv
// Port-level checker for the hole allocator, bound to the top level.
// Depends on hasw_pkg and the assertion macro header.
`include "hole_allocator_with_swap_out_top_defines.svh"

module hasw_checker import hasw_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o,
  input rec_t result_o
);

  // an accepted request keeps the block busy
  `HASW_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  // more records follow while the block is still busy
  `HASW_ASSERT_IMP(a_more_busy, result_valid_o && !result_o.last_record, busy)
  // a load ends its request
  `HASW_ASSERT_IMP(a_load_last, result_valid_o && result_o.record_kind == RecLoad,
                   result_o.last_record)
  // eviction records carry no position and never end a request
  `HASW_ASSERT_IMP(a_evict_pos, result_valid_o && (result_o.record_kind == RecRequeue ||
                   result_o.record_kind == RecDrop),
                   result_o.load_position == '0 && !result_o.last_record)

endmodule

bind hole_allocator_with_swap_out_top hasw_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
